/* rtl/core/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants and types for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HeapWords  = 4096;
    localparam int AddrW      = $clog2(HeapWords);
    localparam int WordW      = 32;
    localparam int FieldW     = 14;
    localparam int FirstHdr   = 3;
    localparam int FreeBytes  = ((HeapWords - 4) / 2) * 8;
    localparam int FreeWords  = FreeBytes / 4;
    localparam int EpiIdx     = FirstHdr + FreeWords;

    localparam logic [1:0] StatOk    = 2'd0;
    localparam logic [1:0] StatNoFit = 2'd1;
    localparam logic [1:0] StatZero  = 2'd2;

    localparam logic OpAlloc = 1'b0;
    localparam logic OpFree  = 1'b1;

    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] addr;
        logic [WordW-1:0] wdata;
    } mem_req_t;

    function automatic logic [WordW-1:0] reset_word(input logic [AddrW-1:0] idx);
        logic [WordW-1:0] v;
        v = '0;
        if (idx == AddrW'(1) || idx == AddrW'(2))
        begin
            v = WordW'(9);
        end
        else if (idx == AddrW'(FirstHdr) || idx == AddrW'(EpiIdx - 1))
        begin
            v = WordW'(FreeBytes);
        end
        else if (idx == AddrW'(EpiIdx))
        begin
            v = WordW'(1);
        end
        return v;
    endfunction

endpackage

/* rtl/core/ffha_heap_mem.sv */
// ----------------------------------------------------------------------------
// ffha_heap_mem
// Heap word memory, one port, registered read data.
// ----------------------------------------------------------------------------
module ffha_heap_mem
    import ffha_pkg::*;
(
    input  logic             clk,
    input  mem_req_t         req,
    output logic [WordW-1:0] rdata
);

    logic [WordW-1:0] mem [HeapWords];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

endmodule

/* rtl/core/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Implicit free list first-fit allocator with boundary-tag coalescing.
// ----------------------------------------------------------------------------
//  channel  | direction | signals
//  in       | input     | in_valid, in_stall, op, req_size, block_addr
//  out      | output    | out_valid, out_stall, status, payload_addr
//
//  After reset a clearing pass writes all HeapWords words;
//  no request is taken meanwhile.
//  Allocate: each block header on the walk is read and checked, then a block is
//  taken whole or split.
//  Free: the same walk up to the block, then merge with free neighbours and write.
//  The single memory port sets the pace. One request at a time; the result
//  register holds under out_stall.
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic [FieldW-1:0] req_size,
    input  logic [FieldW-1:0] block_addr,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [FieldW-1:0] payload_addr
);

    localparam int SzW = AddrW + 3;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WRD, S_WCHK, S_SPLIT1, S_SPLIT2, S_SPLIT3, S_SPLIT4,
        S_NRD, S_NWAIT, S_PRD, S_PWAIT, S_MW1, S_MW2, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [AddrW:0]    cnt_reg, cnt_next;
    logic [AddrW:0]    h_reg, h_next;
    logic [AddrW:0]    tgt_reg, tgt_next;
    logic              op_reg, op_next;
    logic [SzW-1:0]    need_reg, need_next;
    logic [SzW-1:0]    sz_reg, sz_next;
    logic [1:0]        stat_reg, stat_next;
    logic [FieldW-1:0] res_reg, res_next;
    logic              ov_reg, ov_next;
    logic              rd_wait_reg, rd_wait_next;
    mem_req_t          mreq;
    logic [WordW-1:0]  rdata;
    logic [SzW-1:0]    rsz;
    logic              ralloc;
    logic [FieldW:0]   need_calc;

    ffha_heap_mem u_mem (.clk(clk), .req(mreq), .rdata(rdata));

    assign rsz      = {rdata[SzW-1:3], 3'b000};
    assign ralloc   = rdata[0] | (rdata[WordW-1:SzW] != '0);
    assign need_calc = ({1'b0, req_size} + (FieldW+1)'(15)) & ~(FieldW+1)'(7);

    assign in_stall     = (state_reg != S_IDLE) || ov_reg;
    assign out_valid    = ov_reg;
    assign status       = stat_reg;
    assign payload_addr = res_reg;

    function automatic logic [AddrW:0] w_of(input logic [SzW-1:0] s);
        return (AddrW+1)'(s >> 2);
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        h_next       = h_reg;
        tgt_next     = tgt_reg;
        op_next      = op_reg;
        need_next    = need_reg;
        sz_next      = sz_reg;
        stat_next    = stat_reg;
        res_next     = res_reg;
        ov_next      = ov_reg && out_stall;
        rd_wait_next = 1'b0;
        mreq         = '{we: 1'b0, addr: h_reg[AddrW-1:0], wdata: '0};
        unique case (state_reg)
            S_CLEAR:
            begin
                mreq = '{we: 1'b1, addr: cnt_reg[AddrW-1:0],
                         wdata: reset_word(cnt_reg[AddrW-1:0])};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AddrW+1)'(HeapWords - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    op_next   = op;
                    need_next = (req_size <= FieldW'(8)) ? SzW'(16) : SzW'(need_calc);
                    tgt_next  = (AddrW+1)'(block_addr >> 2) - 1'b1;
                    h_next    = (AddrW+1)'(FirstHdr);
                    stat_next = StatOk;
                    res_next  = '0;
                    if (op == OpFree)
                    begin
                        res_next = block_addr;
                        if (block_addr[1:0] != 2'b00 || block_addr < FieldW'(16)
                            || ((block_addr >> 2) > FieldW'(HeapWords)))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_WRD;
                        end
                    end
                    else if (req_size == '0)
                    begin
                        stat_next  = StatZero;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WRD;
                    end
                end
            end
            S_WRD:
            begin
                if (h_reg >= (AddrW+1)'(HeapWords))
                begin
                    if (op_reg == OpAlloc)
                    begin
                        stat_next = StatNoFit;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    mreq.addr  = h_reg[AddrW-1:0];
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                sz_next = rsz;
                if (rsz < SzW'(16) || rdata[WordW-1:SzW] != '0)
                begin
                    if (op_reg == OpAlloc)
                    begin
                        stat_next = StatNoFit;
                    end
                    state_next = S_DONE;
                end
                else if (op_reg == OpFree)
                begin
                    if (h_reg == tgt_reg)
                    begin
                        state_next = ralloc ? S_NRD : S_DONE;
                    end
                    else
                    begin
                        h_next     = h_reg + w_of(rsz);
                        state_next = S_WRD;
                    end
                end
                else if (!ralloc && rsz >= need_reg)
                begin
                    res_next   = FieldW'((h_reg + 1'b1) << 2);
                    state_next = S_SPLIT1;
                end
                else
                begin
                    h_next     = h_reg + w_of(rsz);
                    state_next = S_WRD;
                end
            end
            S_SPLIT1:
            begin
                if (sz_reg - need_reg >= SzW'(16))
                begin
                    mreq = '{we: 1'b1, addr: h_reg[AddrW-1:0],
                             wdata: WordW'(need_reg) | WordW'(1)};
                    state_next = S_SPLIT2;
                end
                else
                begin
                    mreq = '{we: 1'b1, addr: h_reg[AddrW-1:0],
                             wdata: WordW'(sz_reg) | WordW'(1)};
                    need_next  = sz_reg;
                    state_next = S_SPLIT4;
                end
            end
            S_SPLIT2:
            begin
                mreq = '{we: 1'b1, addr: AddrW'(h_reg + w_of(need_reg) - 1'b1),
                         wdata: WordW'(need_reg) | WordW'(1)};
                state_next = S_SPLIT3;
            end
            S_SPLIT3:
            begin
                mreq = '{we: 1'b1, addr: AddrW'(h_reg + w_of(need_reg)),
                         wdata: WordW'(sz_reg - need_reg)};
                h_next  = h_reg + w_of(need_reg);
                sz_next = sz_reg - need_reg;
                state_next = S_MW2;
            end
            S_SPLIT4:
            begin
                mreq = '{we: 1'b1, addr: AddrW'(h_reg + w_of(sz_reg) - 1'b1),
                         wdata: WordW'(sz_reg) | WordW'(1)};
                state_next = S_DONE;
            end
            S_NRD:
            begin
                need_next = sz_reg;
                if (h_reg + w_of(sz_reg) >= (AddrW+1)'(HeapWords))
                begin
                    state_next = S_PRD;
                end
                else
                begin
                    mreq.addr  = AddrW'(h_reg + w_of(sz_reg));
                    state_next = S_NWAIT;
                end
            end
            S_NWAIT:
            begin
                if (!ralloc)
                begin
                    sz_next = sz_reg + rsz;
                end
                state_next = S_PRD;
            end
            S_PRD:
            begin
                mreq.addr  = AddrW'(h_reg - 1'b1);
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (!ralloc)
                begin
                    sz_next = sz_reg + rsz;
                    h_next  = h_reg - w_of(rsz);
                end
                state_next = S_MW1;
            end
            S_MW1:
            begin
                mreq = '{we: 1'b1, addr: h_reg[AddrW-1:0], wdata: WordW'(sz_reg)};
                state_next = S_MW2;
            end
            S_MW2:
            begin
                if (op_reg == OpAlloc)
                begin
                    mreq = '{we: 1'b1, addr: h_reg[AddrW-1:0], wdata: WordW'(sz_reg)};
                    state_next = S_MW1;
                    op_next    = OpFree;
                end
                else
                begin
                    mreq = '{we: 1'b1, addr: AddrW'(h_reg + w_of(sz_reg) - 1'b1),
                             wdata: WordW'(sz_reg)};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            ov_reg      <= 1'b0;
            rd_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ov_reg      <= ov_next;
            rd_wait_reg <= rd_wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        tgt_reg  <= tgt_next;
        op_reg   <= op_next;
        need_reg <= need_next;
        sz_reg   <= sz_next;
        stat_reg <= stat_next;
        res_reg  <= res_next;
    end

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("ready while busy");
    a_stat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3)) else $error("bad status");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid) else $error("result lost");
    a_no_rd_wait: assert property (@(posedge clk) disable iff (!rst_n)
        !rd_wait_reg) else $error("stray wait");
`endif

endmodule
